// File: rtl/core/rotation_g_matrix_element_top_assert.svh
// Assertion helpers for the G matrix element block.
`ifndef ROTATION_G_MATRIX_ELEMENT_TOP_ASSERT_SVH
`define ROTATION_G_MATRIX_ELEMENT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RGME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RGME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rgme_pkg.sv
package rgme_pkg;

  localparam int unsigned MAX_DEGREE = 31;

  localparam int DEG_W  = 5;
  localparam int KIND_W = 3;
  localparam int ROW_W  = 7;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // working widths
  localparam int IDX_W      = 8;
  localparam int OP_W       = 7;
  localparam int PROD_W     = 2 * OP_W;
  localparam int NUM_W      = 12;
  localparam int DEN_W      = 14;
  localparam int FRAC_SHIFT = 50;
  localparam int Y_W        = NUM_W + FRAC_SHIFT;
  localparam int ROOT_W     = Y_W / 2;
  localparam int TERM_W     = Y_W + 2;
  localparam int DIV_STAGES = Y_W / 2;
  localparam int SQ_STAGES  = ROOT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_X,
    KIND_Y,
    KIND_Z,
    KIND_ZHAT,
    KIND_ZHAT_INV
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_DEG_ZERO,
    ST_RANGE,
    ST_KIND
  } status_e;

  typedef enum logic [1:0] {
    CLS_XY,
    CLS_Z,
    CLS_INV
  } cls_e;

  typedef struct packed {
    status_e         status;
    logic            hit;
    logic            neg;
    cls_e            cls;
    logic [OP_W-1:0] pa;
    logic [OP_W-1:0] pb;
    logic [OP_W-1:0] t;
  } s1_t;

  typedef struct packed {
    status_e          status;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } s2_t;

  typedef struct packed {
    status_e          status;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [Y_W-1:0]   quo;
  } div_t;

  typedef struct packed {
    status_e           status;
    logic              neg;
    logic [Y_W-1:0]    rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage

// File: rtl/core/rotation_g_matrix_element_top.sv
// G matrix element generator: one element request per cycle, one result per request,
// in order. An accepted beat passes through one decode stage,
// one stage of two small multipliers, a 31-stage radix-4 restoring divider (2 quotient
// bits per stage) and a 31-stage square root (one root bit per stage), then the output
// register. A stall on the result side holds the whole pipeline; otherwise a new beat
// is taken every cycle. Configuration is written through a port that is always ready.
module rotation_g_matrix_element_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rgme_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rgme_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rgme_pkg::ROW_W-1:0]       row_index_i,
  input  logic [rgme_pkg::COL_W-1:0]       column_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rgme_pkg::VAL_W-1:0] element_value_o,
  output logic [rgme_pkg::STAT_W-1:0]      status_o
);
  import rgme_pkg::*;

  logic [DEG_W-1:0]  deg_q;
  logic [KIND_W-1:0] kind_q;
  logic              en;

  logic  s1_valid_q, s2_valid_q;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;

  logic  div_valid_q [DIV_STAGES];
  div_t  div_q       [DIV_STAGES];
  div_t  div_d       [DIV_STAGES];
  logic  sq_valid_q  [SQ_STAGES];
  sq_t   sq_q        [SQ_STAGES];
  sq_t   sq_d        [SQ_STAGES];

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  logic [STAT_W-1:0]       out_status_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q  <= '0;
      kind_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEGREE: deg_q  <= cfg_data_i;
        CFG_KIND:   kind_q <= cfg_data_i[KIND_W-1:0];
        default:    ;
      endcase
    end
  end

  // Decode: locate the placement that covers the requested element.
  always_comb begin
    logic [DEG_W-1:0] l_sat;
    logic [IDX_W-1:0] l8, r8, c8, m8, two_l, nrows, ncols;
    l_sat = (32'(deg_q) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : deg_q;
    l8    = IDX_W'(l_sat);
    two_l = l8 << 1;
    r8    = IDX_W'(row_index_i) + IDX_W'(1);
    c8    = IDX_W'(column_index_i) + IDX_W'(1);
    m8    = two_l + IDX_W'(2) - c8;
    ncols = two_l + IDX_W'(1);
    nrows = (kind_q <= KIND_Z) ? two_l + IDX_W'(3) : two_l + IDX_W'(1);

    s1_d        = '0;
    s1_d.status = ST_OK;
    s1_d.cls    = CLS_XY;
    s1_d.t      = OP_W'(two_l + IDX_W'(1));

    if (kind_q > KIND_ZHAT_INV) begin
      s1_d.status = ST_KIND;
    end else if (l8 == '0) begin
      s1_d.status = ST_DEG_ZERO;
    end else if (IDX_W'(row_index_i) >= nrows || IDX_W'(column_index_i) >= ncols) begin
      s1_d.status = ST_RANGE;
    end else begin
      case (kind_q)
        KIND_X: begin
          if (r8 == c8) begin
            s1_d.neg = (c8 <= l8);
            if (c8 == l8 + IDX_W'(2)) begin
              s1_d.hit = 1'b1;
              s1_d.pa  = OP_W'(two_l);
              s1_d.pb  = OP_W'(l8 + IDX_W'(1));
            end else if (c8 != l8 + IDX_W'(1)) begin
              s1_d.hit = 1'b1;
              s1_d.pa  = OP_W'(m8);
              s1_d.pb  = OP_W'(m8 + IDX_W'(1));
            end
          end else if (r8 == c8 + IDX_W'(2)) begin
            s1_d.neg = (c8 >= l8 + IDX_W'(1));
            if (c8 == l8 + IDX_W'(1)) begin
              s1_d.hit = 1'b1;
              s1_d.pa  = OP_W'(two_l + IDX_W'(2));
              s1_d.pb  = OP_W'(l8 + IDX_W'(2));
            end else if (c8 != l8) begin
              s1_d.hit = 1'b1;
              s1_d.pa  = OP_W'(c8);
              s1_d.pb  = OP_W'(c8 + IDX_W'(1));
            end
          end
        end
        KIND_Y: begin
          if (r8 + c8 == two_l + IDX_W'(2)) begin
            s1_d.hit = 1'b1;
            s1_d.neg = (c8 >= l8 + IDX_W'(1));
            if (c8 == l8) begin
              s1_d.pa = OP_W'(two_l);
              s1_d.pb = OP_W'(l8 + IDX_W'(1));
            end else if (c8 == l8 + IDX_W'(1)) begin
              s1_d.pa = OP_W'(two_l + IDX_W'(2));
              s1_d.pb = OP_W'(l8 + IDX_W'(2));
            end else begin
              s1_d.pa = OP_W'(c8);
              s1_d.pb = OP_W'(c8 + IDX_W'(1));
            end
          end else if (r8 + c8 == two_l + IDX_W'(4)) begin
            s1_d.neg = (c8 >= l8 + IDX_W'(3));
            if (c8 != l8 + IDX_W'(1) && c8 != l8 + IDX_W'(2)) begin
              s1_d.hit = 1'b1;
              s1_d.pa  = OP_W'(m8);
              s1_d.pb  = OP_W'(m8 + IDX_W'(1));
            end
          end
        end
        KIND_Z: begin
          s1_d.cls = CLS_Z;
          s1_d.hit = (r8 == c8 + IDX_W'(1));
          s1_d.pa  = OP_W'(c8);
          s1_d.pb  = OP_W'(m8);
        end
        KIND_ZHAT: begin
          s1_d.cls = CLS_Z;
          s1_d.hit = (r8 == c8);
          s1_d.pa  = OP_W'(c8);
          s1_d.pb  = OP_W'(m8);
        end
        KIND_ZHAT_INV: begin
          s1_d.cls = CLS_INV;
          s1_d.hit = (r8 == c8);
          s1_d.pa  = OP_W'(c8);
          s1_d.pb  = OP_W'(m8);
        end
        default: ;
      endcase
    end
  end

  // Form numerator and denominator; a miss divides zero by one.
  always_comb begin
    logic [PROD_W-1:0] p, q;
    logic [OP_W-1:0]   t2;
    t2 = s1_q.t + OP_W'(2);
    p  = s1_q.pa * s1_q.pb;
    q  = s1_q.t * t2;
    s2_d.status = s1_q.status;
    s2_d.neg    = s1_q.neg;
    s2_d.num    = '0;
    s2_d.den    = DEN_W'(1);
    if (s1_q.hit && s1_q.status == ST_OK) begin
      case (s1_q.cls)
        CLS_XY: begin
          s2_d.num = p[NUM_W-1:0];
          s2_d.den = {q[DEN_W-3:0], 2'b00};
        end
        CLS_Z: begin
          s2_d.num = p[NUM_W-1:0];
          s2_d.den = q[DEN_W-1:0];
        end
        CLS_INV: begin
          s2_d.num = q[NUM_W-1:0];
          s2_d.den = p[DEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // Divider: two quotient bits a stage, dividend is num followed by zeros.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    div_t din;
    logic vin;
    if (s == 0) begin : g_first
      always_comb begin
        din        = '0;
        din.status = s2_q.status;
        din.neg    = s2_q.neg;
        din.num    = s2_q.num;
        din.den    = s2_q.den;
        vin        = s2_valid_q;
      end
    end else begin : g_rest
      assign din = div_q[s-1];
      assign vin = div_valid_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0]   r1, r2;
      logic             ge1, ge2;
      logic [DEN_W-1:0] r1s;
      r1  = {din.rem, din.num[NUM_W-1]};
      ge1 = r1 >= {1'b0, din.den};
      r1s = ge1 ? DEN_W'(r1 - {1'b0, din.den}) : r1[DEN_W-1:0];
      r2  = {r1s, din.num[NUM_W-2]};
      ge2 = r2 >= {1'b0, din.den};
      div_d[s]     = din;
      div_d[s].rem = ge2 ? DEN_W'(r2 - {1'b0, din.den}) : r2[DEN_W-1:0];
      div_d[s].quo = {din.quo[Y_W-3:0], ge1, ge2};
      div_d[s].num = din.num << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_valid_q[s] <= 1'b0;
      end else if (en) begin
        div_valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[s] <= div_d[s];
      end
    end
  end

  // Square root: decide one root bit a stage, most significant first.
  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
    localparam int B = SQ_STAGES - 1 - s;
    sq_t  sin;
    logic vin;
    if (s == 0) begin : g_first
      always_comb begin
        sin.status = div_q[DIV_STAGES-1].status;
        sin.neg    = div_q[DIV_STAGES-1].neg;
        sin.rem    = div_q[DIV_STAGES-1].quo;
        sin.root   = '0;
        vin        = div_valid_q[DIV_STAGES-1];
      end
    end else begin : g_rest
      assign sin = sq_q[s-1];
      assign vin = sq_valid_q[s-1];
    end

    always_comb begin
      logic [TERM_W-1:0] term;
      logic              take;
      term = (TERM_W'(sin.root) << (B + 1)) + (TERM_W'(1) << (2 * B));
      take = {2'b00, sin.rem} >= term;
      sq_d[s] = sin;
      if (take) begin
        sq_d[s].rem     = Y_W'({2'b00, sin.rem} - term);
        sq_d[s].root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[s] <= 1'b0;
      end else if (en) begin
        sq_valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[s] <= sq_d[s];
      end
    end
  end

  // Round the doubled root to nearest, then apply the sign.
  always_comb begin
    logic [VAL_W-1:0] mag;
    mag         = VAL_W'(({1'b0, sq_q[SQ_STAGES-1].root} + (ROOT_W + 1)'(1)) >> 1);
    out_value_d = sq_q[SQ_STAGES-1].neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_valid_q[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q  <= out_value_d;
      out_status_q <= sq_q[SQ_STAGES-1].status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign element_value_o = out_value_q;
  assign status_o        = out_status_q;

`include "rotation_g_matrix_element_top_assert.svh"

  `RGME_ASSERT_IMP(a_err_value_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, element_value_o == '0, "error status carries a nonzero value")
  `RGME_ASSERT_IMP(a_stall_only_on_hold, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a held result")
  `RGME_ASSERT_IMP(a_miss_zero_num, clk_i, rst_ni, s2_valid_q && s2_q.status != ST_OK, s2_q.num == '0, "error item enters divider with nonzero numerator")
  `RGME_ASSERT_IMP(a_div_rem_bound, clk_i, rst_ni, div_valid_q[DIV_STAGES-1], div_q[DIV_STAGES-1].rem < div_q[DIV_STAGES-1].den, "divider remainder not below divisor")
  `RGME_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, s1_valid_q, "accepted beat lost at decode")

endmodule

// File: sim/rgme_checker.sv
`timescale 1ns / 100ps

module rgme_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [rgme_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rgme_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [rgme_pkg::ROW_W-1:0]        row_index_i,
  input  logic [rgme_pkg::COL_W-1:0]        column_index_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [rgme_pkg::VAL_W-1:0] element_value_i,
  input  logic [rgme_pkg::STAT_W-1:0]       status_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                elements_seen_o
);
  import rgme_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
  } element_t;

  element_t                element_q[$];
  logic     [DEG_W-1:0]    degree_q;
  logic     [KIND_W-1:0]   kind_q;

  assign pending_o = element_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic element_t predict_element(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    element_t    e;
    logic [63:0] l, r, c, q, k, p, nrows, y, mag;
    logic [63:0] hn, hd;
    logic        hit, hneg;
    e    = '0;
    l    = (degree_q > MAX_DEGREE) ? MAX_DEGREE : degree_q;
    hit  = 0;
    hneg = 0;
    hn   = 0;
    hd   = 1;
    if (kind_q > KIND_ZHAT_INV) begin
      e.status = ST_KIND;
    end else if (l == 0) begin
      e.status = ST_DEG_ZERO;
    end else begin
      nrows = (kind_q <= KIND_Z) ? 2 * l + 3 : 2 * l + 1;
      if (row >= nrows || col >= 2 * l + 1) begin
        e.status = ST_RANGE;
      end else begin
        r = row + 1;
        c = col + 1;
        q = (2 * l + 1) * (2 * l + 3);
        // later placements overwrite earlier ones
        if (kind_q == KIND_X) begin
          for (k = 1; k + 1 <= l; k++) begin
            if (r == 2 + k && c == k) begin hit = 1; hneg = 0; hn = k * (k + 1); hd = 4 * q; end
            if (r == 2 * l + 2 - k && c == 2 * l + 2 - k) begin
              hit = 1; hneg = 0; hn = k * (k + 1); hd = 4 * q;
            end
          end
          for (k = 1; k <= l; k++) begin
            p = (2 * l + 2 - k) * (2 * l + 3 - k);
            if (r == k && c == k) begin hit = 1; hneg = 1; hn = p; hd = 4 * q; end
            if (r == 2 * l + 4 - k && c == 2 * l + 2 - k) begin
              hit = 1; hneg = 1; hn = p; hd = 4 * q;
            end
          end
          if (r == l + 2 && c == l + 2) begin
            hit = 1; hneg = 0; hn = 2 * l * (l + 1); hd = 4 * q;
          end
          if (r == l + 3 && c == l + 1) begin
            hit = 1; hneg = 1; hn = 2 * (l + 1) * (l + 2); hd = 4 * q;
          end
        end else if (kind_q == KIND_Y) begin
          for (k = 1; k + 1 <= l; k++) begin
            if (r == 2 * l + 2 - k && c == k) begin
              hit = 1; hneg = 0; hn = k * (k + 1); hd = 4 * q;
            end
            if (r == 2 + k && c == 2 * l + 2 - k) begin
              hit = 1; hneg = 1; hn = k * (k + 1); hd = 4 * q;
            end
          end
          for (k = 1; k <= l; k++) begin
            p = (2 * l + 2 - k) * (2 * l + 3 - k);
            if (r == k && c == 2 * l + 2 - k) begin hit = 1; hneg = 1; hn = p; hd = 4 * q; end
            if (r == 2 * l + 4 - k && c == k) begin hit = 1; hneg = 0; hn = p; hd = 4 * q; end
          end
          if (r == l + 2 && c == l) begin
            hit = 1; hneg = 0; hn = 2 * l * (l + 1); hd = 4 * q;
          end
          if (r == l + 1 && c == l + 1) begin
            hit = 1; hneg = 1; hn = 2 * (l + 1) * (l + 2); hd = 4 * q;
          end
        end else begin
          for (k = 1; k <= 2 * l + 1; k++) begin
            p = k * (2 * l + 2 - k);
            if (kind_q == KIND_Z) begin
              if (r == k + 1 && c == k) begin hit = 1; hneg = 0; hn = p; hd = q; end
            end else if (r == k && c == k) begin
              hit  = 1;
              hneg = 0;
              hn   = (kind_q == KIND_ZHAT) ? p : q;
              hd   = (kind_q == KIND_ZHAT) ? q : p;
            end
          end
        end
        if (hit && hd != 0) begin
          y   = (hn << 50) / hd;
          mag = (int_sqrt(y) + 1) >> 1;
          e.value = hneg ? -mag[VAL_W-1:0] : mag[VAL_W-1:0];
        end
        e.status = ST_OK;
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    element_t want;
    if (!rst_ni) begin
      degree_q        <= '0;
      kind_q          <= '0;
      fail_count_o    = 0;
      elements_seen_o <= 0;
      element_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        elements_seen_o <= elements_seen_o + 1;
        if (element_q.size() == 0) begin
          report_mismatch("unexpected beat", element_value_i, 0);
        end else begin
          want = element_q.pop_front();
          if (element_value_i !== want.value)
            report_mismatch("element_value", element_value_i, want.value);
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
        end
      end
      if (in_valid_i && !in_stall_i)
        element_q.push_back(predict_element(row_index_i, column_index_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_DEGREE) degree_q <= cfg_data_i;
        else                           kind_q   <= cfg_data_i[KIND_W-1:0];
      end
    end
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import rgme_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LATENCY        = 65;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 0;
  logic                  in_stall_o;
  logic [ROW_W-1:0]      row_index_i = '0;
  logic [COL_W-1:0]      column_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 0;
  logic signed [VAL_W-1:0] element_value_o;
  logic [STAT_W-1:0]     status_o;
  int                    fail_count, pending, elements_seen;
  int                    idle_cycles = 0;
  int                    requests_sent = 0;
  bit                    quiet_phase = 0;

  always #2 clk_i = ~clk_i;

  rotation_g_matrix_element_top DUT (.*);

  rgme_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .row_index_i, .column_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .element_value_i(element_value_o),
    .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending),
    .elements_seen_o(elements_seen)
  );

  // random result-side stall bursts
  initial begin
    int n;
    @(posedge rst_ni);
    while (1) begin
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk_i);
      if (quiet_phase) out_stall_i <= 0;
      else             out_stall_i <= ($urandom_range(0, 2) == 0);
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("rotation_g_matrix_element_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // leave valid high so that writes can follow back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_matrix(logic [DEG_W-1:0] deg, logic [KIND_W-1:0] kind);
    write_reg(CFG_DEGREE, deg);
    write_reg(CFG_KIND, {2'b00, kind});
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // one request; hold valid across back-to-back beats
  task automatic send_request(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1;
    row_index_i    <= row;
    column_index_i <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic finish_burst();
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [DEG_W-1:0]  deg;
    logic [KIND_W-1:0] kind;
    int                span;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: error orderings, field extremes, every kind
    set_matrix(0, KIND_X);
    send_request(0, 0);
    send_request(127, 63);
    finish_burst();
    drain();
    set_matrix(0, 7);
    send_request(0, 0);
    finish_burst();
    drain();
    set_matrix(31, 5);
    send_request(5, 5);
    finish_burst();
    drain();
    for (int kd = KIND_X; kd <= KIND_ZHAT_INV; kd++) begin
      set_matrix(1, KIND_W'(kd));
      send_request(0, 0);
      send_request(1, 0);
      send_request(2, 1);
      send_request(4, 2);
      send_request(5, 2);
      finish_burst();
      drain();
    end
    set_matrix(31, KIND_ZHAT_INV);
    send_request(62, 62);
    send_request(63, 62);
    send_request(127, 0);
    finish_burst();
    drain();
    set_matrix(31, KIND_X);
    send_request(64, 62);
    send_request(65, 62);
    send_request(0, 63);
    finish_burst();
    drain();

    // random phases: mostly in-range, small degrees favoured
    for (int ph = 0; ph < 30; ph++) begin
      deg  = ($urandom_range(0, 3) == 0) ? DEG_W'($urandom_range(0, 31))
                                         : DEG_W'($urandom_range(1, 6));
      kind = ($urandom_range(0, 9) == 0) ? KIND_W'($urandom_range(5, 7))
                                         : KIND_W'($urandom_range(0, 4));
      if (ph == 29) begin
        deg  = 31;
        kind = KIND_Y;
      end
      quiet_phase = (ph >= 27);
      set_matrix(deg, kind);
      span = 2 * deg + 3;
      repeat (50) begin
        if ($urandom_range(0, 9) == 0)
          send_request(ROW_W'($urandom_range(0, 127)), COL_W'($urandom_range(0, 63)));
        else
          send_request(ROW_W'($urandom_range(0, span - 1)),
                       COL_W'($urandom_range(0, span - 3)));
      end
      finish_burst();
      drain();
    end

    $display("%0d element requests over 30 random settings plus directed corners", requests_sent);
    $display("%0d results compared, %0d mismatches", elements_seen, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("rotation_g_matrix_element_top verification clean");
    else
      $display("rotation_g_matrix_element_top verification failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rgme_pkg.sv
rtl/core/rotation_g_matrix_element_top.sv
sim/rgme_checker.sv
sim/tb.sv
